// File: rtl/qfsc_pkg.sv
`default_nettype none

package qfsc_pkg;

    // Angle format and table resolution
    localparam int STEPS_PER_DEGREE = 10;
    localparam int FRAC_BITS        = 8;

    localparam int ANGLE_W  = 20;
    localparam int VALUE_W  = 16;
    localparam int SAMPLE_W = 16;

    localparam int STEPS_QUARTER = 90 * STEPS_PER_DEGREE;
    localparam int ROM_DEPTH     = STEPS_QUARTER + 2;
    localparam int UNITS_QUARTER = STEPS_QUARTER * (1 << FRAC_BITS);

    localparam int IDX_W     = $clog2(ROM_DEPTH);
    localparam int T_W       = $clog2(UNITS_QUARTER + 1);
    localparam int FRAC_W    = (FRAC_BITS > 0) ? FRAC_BITS : 1;
    localparam int WEIGHT_W  = FRAC_W + 1;
    localparam int FRAC_ONE  = 1 << FRAC_BITS;
    localparam int FRAC_HALF = (FRAC_BITS > 0) ? (1 << (FRAC_BITS - 1)) : 0;
    localparam logic [FRAC_W-1:0] FRAC_MASK = FRAC_W'(FRAC_ONE - 1);

    // Quarter count by reciprocal multiply on the whole-step part of the angle
    localparam int STEP_W   = ANGLE_W - FRAC_BITS;
    localparam int D_W      = $clog2(STEPS_QUARTER + 1);
    localparam int RECIP_K  = STEP_W;
    localparam int RECIP_M  = (1 << STEP_W) / STEPS_QUARTER;
    localparam int M_W      = (RECIP_M > 0) ? $clog2(RECIP_M + 1) : 1;
    localparam int PROD1_W  = STEP_W + M_W;
    localparam int N_MAX    = ((1 << STEP_W) - 1) / STEPS_QUARTER;
    localparam int N_W      = (N_MAX < 3) ? 2 : $clog2(N_MAX + 1);
    localparam int PROD2_W  = N_W + D_W;
    localparam int REM_W    = ((STEP_W > D_W) ? STEP_W : D_W) + 1;

    // Queue between fold front end and interpolation back end
    localparam int QUEUE_DEPTH = 8;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int LEVEL_W     = QUEUE_AW + 1;

    // Table build constants, Q2.30
    localparam logic [63:0] PI_Q30    = 64'd3373259426;
    localparam logic [63:0] ONE_Q30   = 64'd1073741824;
    localparam logic [63:0] ROM_DENOM = 64'(180 * STEPS_PER_DEGREE);
    localparam logic [63:0] ROM_DENOM_HALF = 64'((180 * STEPS_PER_DEGREE) / 2);
    localparam logic signed [63:0] SAMPLE_MAX = 64'sd32767;

    typedef enum logic {
        ACT_COSINE = 1'b0,
        ACT_SINE   = 1'b1
    } t_action;

    typedef enum logic [1:0] {
        QUAD_0 = 2'd0,
        QUAD_1 = 2'd1,
        QUAD_2 = 2'd2,
        QUAD_3 = 2'd3
    } t_quad;

    typedef logic [SAMPLE_W-1:0] t_rom [ROM_DEPTH];

    // Folded item handed from front end to back end
    typedef struct packed {
        logic [IDX_W-1:0]  idx;
        logic [FRAC_W-1:0] frac;
        logic              neg;
    } t_fold_item;

    // Unsigned long division, used only while building the table
    function automatic logic [63:0] udiv64(input logic [63:0] num,
                                           input logic [63:0] den);
        logic [63:0] quo;
        logic [64:0] rem;
        quo = '0;
        rem = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[63:0], num[b]};
            if (rem >= {1'b0, den}) begin
                rem    = rem - {1'b0, den};
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // cos(x) for x in [0, pi/2], Taylor series in Q2.30
    function automatic logic signed [63:0] cos_q30(input logic [63:0] x);
        logic [63:0]        x2;
        logic [63:0]        term;
        logic [63:0]        div;
        logic signed [63:0] sum;
        x2   = (x * x) >> 30;
        term = ONE_Q30;
        sum  = $signed(ONE_Q30);
        for (int k = 1; k <= 12; k++) begin
            if (term != 64'd0) begin
                div  = 64'((2 * k - 1) * (2 * k));
                term = udiv64((term * x2) >> 30, div);
                if (k[0]) begin
                    sum = sum - $signed(term);
                end else begin
                    sum = sum + $signed(term);
                end
            end
        end
        return sum;
    endfunction

    // Quarter-wave cosine table, Q1.15, two trailing zero entries
    function automatic t_rom build_cos_rom();
        t_rom               rom;
        logic [63:0]        x;
        logic signed [63:0] c;
        logic signed [63:0] q;
        for (int i = 0; i < STEPS_QUARTER; i++) begin
            x = udiv64(64'(i) * PI_Q30 + ROM_DENOM_HALF, ROM_DENOM);
            c = cos_q30(x);
            if (c < 0) begin
                c = 64'sd0;
            end
            q = (c + 64'sd16384) >>> 15;
            if (q > SAMPLE_MAX) begin
                q = SAMPLE_MAX;
            end
            rom[i] = SAMPLE_W'(q);
        end
        rom[STEPS_QUARTER]     = '0;
        rom[STEPS_QUARTER + 1] = '0;
        return rom;
    endfunction

endpackage

`default_nettype wire

// File: rtl/quadrant_folded_sine_cosine_lut_top.sv
// Sine/cosine by quarter-wave table with linear interpolation.
// Path: fold front end, fold queue, then table read, weighting and output register.
// Throughput: one item per cycle unless stalled; the 8-entry fold queue sets how far the front end runs ahead.
// Reset (synchronous, active low) empties all pipeline stages and the queue.
// The cosine table is a constant built at elaboration and needs no initialization.
`default_nettype none

module quadrant_folded_sine_cosine_lut_top import qfsc_pkg::*; (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_valid,
    output logic                           o_ready,
    input  wire logic                      i_action,
    input  wire logic [ANGLE_W-1:0]        i_angle,
    output logic                           o_valid,
    input  wire logic                      i_ready,
    output logic signed [VALUE_W-1:0]      o_value
);

    logic               push;
    t_fold_item         push_item;
    logic               q_valid;
    t_fold_item         q_item;
    logic               pop;
    logic [LEVEL_W-1:0] q_level;

    qfsc_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_action  (i_action),
        .i_angle   (i_angle),
        .i_q_level (q_level),
        .o_push    (push),
        .o_item    (push_item)
    );

    qfsc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_item  (q_item),
        .o_level (q_level)
    );

    qfsc_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_item    (q_item),
        .o_pop     (pop),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_value   (o_value)
    );

endmodule

`default_nettype wire

// File: rtl/qfsc_front.sv
`default_nettype none

module qfsc_front import qfsc_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic               i_action,
    input  wire logic [ANGLE_W-1:0] i_angle,
    input  wire logic [LEVEL_W-1:0] i_q_level,
    output logic                    o_push,
    output t_fold_item              o_item
);

    logic                  r_s1_v, r_s2_v, r_s3_v;
    logic                  r_s1_act, r_s2_act, r_s3_act;
    logic [STEP_W-1:0]     r_s1_a, r_s2_a, r_s3_rem;
    logic [FRAC_W-1:0]     r_s1_low, r_s2_low, r_s3_low;
    logic [PROD1_W-1:0]    r_s1_prod;
    logic [N_W-1:0]        r_s2_n, r_s3_n;
    logic [PROD2_W-1:0]    r_s2_prod;

    logic                  accept;
    logic [LEVEL_W:0]      occupancy;
    logic [N_W-1:0]        n_est;
    logic [REM_W-1:0]      rem0;
    logic                  over;
    logic [STEP_W-1:0]     n_rem;
    logic [N_W-1:0]        n_quarters;
    t_quad                 quad;
    logic                  mirror;
    logic                  neg;
    logic [ANGLE_W-1:0]    rem_units;
    logic [T_W-1:0]        rem_t;
    logic [T_W-1:0]        t;

    // Credit: items in flight here plus queued items never exceed the queue
    assign occupancy = (LEVEL_W + 1)'(i_q_level) + (LEVEL_W + 1)'(r_s1_v)
                     + (LEVEL_W + 1)'(r_s2_v) + (LEVEL_W + 1)'(r_s3_v);
    assign o_ready   = occupancy < (LEVEL_W + 1)'(QUEUE_DEPTH);
    assign accept    = i_valid && o_ready;

    // Quarter estimate, never above the true count, at most one below
    assign n_est = N_W'(r_s1_prod >> RECIP_K);

    // One-step correction of the estimate
    assign rem0  = REM_W'(r_s2_a) - REM_W'(r_s2_prod);
    assign over  = rem0 >= REM_W'(STEPS_QUARTER);
    assign n_rem = over ? STEP_W'(rem0 - REM_W'(STEPS_QUARTER)) : STEP_W'(rem0);
    assign n_quarters = over ? (r_s2_n + N_W'(1)) : r_s2_n;

    // Valid pipeline, always advancing
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
        end else begin
            r_s1_v <= accept;
            r_s2_v <= r_s1_v;
            r_s3_v <= r_s2_v;
        end
    end

    // Payload pipeline
    always_ff @(posedge i_clk) begin
        r_s1_act  <= i_action;
        r_s1_a    <= STEP_W'(i_angle >> FRAC_BITS);
        r_s1_low  <= FRAC_W'(i_angle) & FRAC_MASK;
        r_s1_prod <= PROD1_W'(STEP_W'(i_angle >> FRAC_BITS)) * PROD1_W'(RECIP_M);

        r_s2_act  <= r_s1_act;
        r_s2_a    <= r_s1_a;
        r_s2_low  <= r_s1_low;
        r_s2_n    <= n_est;
        r_s2_prod <= PROD2_W'(n_est) * PROD2_W'(STEPS_QUARTER);

        r_s3_act  <= r_s2_act;
        r_s3_low  <= r_s2_low;
        r_s3_rem  <= n_rem;
        r_s3_n    <= n_quarters;
    end

    // Quadrant fold and sign
    assign quad = t_quad'(r_s3_n[1:0]);

    always_comb begin
        if (t_action'(r_s3_act) == ACT_SINE) begin
            mirror = (quad == QUAD_0) || (quad == QUAD_2);
            neg    = (quad == QUAD_2) || (quad == QUAD_3);
        end else begin
            mirror = (quad == QUAD_1) || (quad == QUAD_3);
            neg    = (quad == QUAD_1) || (quad == QUAD_2);
        end
    end

    assign rem_units = (ANGLE_W'(r_s3_rem) << FRAC_BITS) | ANGLE_W'(r_s3_low);
    assign rem_t     = T_W'(rem_units);
    assign t         = mirror ? (T_W'(UNITS_QUARTER) - rem_t) : rem_t;

    assign o_push      = r_s3_v;
    assign o_item.idx  = IDX_W'(t >> FRAC_BITS);
    assign o_item.frac = FRAC_W'(t) & FRAC_MASK;
    assign o_item.neg  = neg;

endmodule

`default_nettype wire

// File: rtl/qfsc_queue.sv
`default_nettype none

module qfsc_queue import qfsc_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_push,
    input  wire t_fold_item         i_item,
    input  wire logic               i_pop,
    output logic                    o_valid,
    output t_fold_item              o_item,
    output logic [LEVEL_W-1:0]      o_level
);

    t_fold_item            r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   r_wr, r_rd;
    logic [LEVEL_W-1:0]    r_level;
    logic                  do_pop;

    assign do_pop  = i_pop && (r_level != '0);
    assign o_valid = r_level != '0;
    assign o_item  = r_mem[r_rd];
    assign o_level = r_level;

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_level <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + QUEUE_AW'(1);
            end
            if (do_pop) begin
                r_rd <= r_rd + QUEUE_AW'(1);
            end
            r_level <= r_level + LEVEL_W'(i_push) - LEVEL_W'(do_pop);
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

endmodule

`default_nettype wire

// File: rtl/qfsc_back.sv
`default_nettype none

module qfsc_back import qfsc_pkg::*; (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_q_valid,
    input  wire t_fold_item                i_item,
    output logic                           o_pop,
    output logic                           o_valid,
    input  wire logic                      i_ready,
    output logic signed [VALUE_W-1:0]      o_value
);

    localparam t_rom COS_ROM = build_cos_rom();
    localparam int   P_W     = SAMPLE_W + WEIGHT_W;
    localparam int   SUM_W   = P_W + 1;
    localparam logic [SUM_W-1:0] POS_MAX = SUM_W'(32767);

    logic                    r_v1, r_v2, r_v3;
    logic [SAMPLE_W-1:0]     r_lo, r_hi;
    logic [FRAC_W-1:0]       r_frac;
    logic                    r_neg1, r_neg2;
    logic [P_W-1:0]          r_p_lo, r_p_hi;
    logic [VALUE_W-1:0]      r_value;

    logic                    en1, en2, en3;
    logic [IDX_W-1:0]        idx_hi;
    logic [WEIGHT_W-1:0]     w_lo;
    logic [SUM_W-1:0]        sum;
    logic [SUM_W-1:0]        v;
    logic [VALUE_W-1:0]      mag;

    // Stall chain from the output register back to the queue
    assign en3   = !r_v3 || i_ready;
    assign en2   = !r_v2 || en3;
    assign en1   = !r_v1 || en2;
    assign o_pop = i_q_valid && en1;

    assign idx_hi = i_item.idx + IDX_W'(1);
    assign w_lo   = WEIGHT_W'(FRAC_ONE) - WEIGHT_W'(r_frac);

    // Round to nearest and saturate; the sign is applied in the output register
    assign sum = SUM_W'(r_p_lo) + SUM_W'(r_p_hi) + SUM_W'(FRAC_HALF);
    assign v   = sum >> FRAC_BITS;
    assign mag = (v > POS_MAX) ? VALUE_W'(POS_MAX) : VALUE_W'(v);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (en1) begin
                r_v1 <= i_q_valid;
            end
            if (en2) begin
                r_v2 <= r_v1;
            end
            if (en3) begin
                r_v3 <= r_v2;
            end
        end
    end

    // Table read: both neighboring samples
    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_lo   <= COS_ROM[i_item.idx];
            r_hi   <= COS_ROM[idx_hi];
            r_frac <= i_item.frac;
            r_neg1 <= i_item.neg;
        end
    end

    // Weighted samples
    always_ff @(posedge i_clk) begin
        if (en2) begin
            r_p_lo <= P_W'(r_lo) * P_W'(w_lo);
            r_p_hi <= P_W'(r_hi) * P_W'(r_frac);
            r_neg2 <= r_neg1;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (en3) begin
            r_value <= r_neg2 ? (VALUE_W'(0) - mag) : mag;
        end
    end

    assign o_valid = r_v3;
    assign o_value = $signed(r_value);

endmodule

`default_nettype wire

// File: rtl/qfsc_checker.sv
`default_nettype none

module qfsc_checker import qfsc_pkg::*; (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_valid,
    input  wire logic                      o_ready,
    input  wire logic                      i_action,
    input  wire logic [ANGLE_W-1:0]        i_angle,
    input  wire logic                      o_valid,
    input  wire logic                      i_ready,
    input  wire logic signed [VALUE_W-1:0] o_value
);

    logic [7:0] r_outstanding;
    logic       in_acc;
    logic       out_acc;

    assign in_acc  = i_valid && o_ready;
    assign out_acc = o_valid && i_ready;

    // Items accepted but not yet delivered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_outstanding <= '0;
        end else begin
            r_outstanding <= r_outstanding + 8'(in_acc) - 8'(out_acc);
        end
    end

    // Reset empties the output register
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_value))
        else $error("stalled result changed");

    // No result without an item that caused it
    a_no_invent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> r_outstanding != 8'd0)
        else $error("result without pending item");

    // Negative results stop at -32767
    a_no_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_value != 16'sh8000)
        else $error("result reached -32768");

    // Queue credit plus back-end stages bound the pending items
    a_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_outstanding <= 8'(QUEUE_DEPTH + 3))
        else $error("too many pending items");

endmodule

bind quadrant_folded_sine_cosine_lut_top qfsc_checker u_qfsc_checker (.*);

`default_nettype wire

// File: tb/tb_quadrant_folded_sine_cosine_lut_top.sv
`default_nettype none

module tb_quadrant_folded_sine_cosine_lut_top;
    import qfsc_pkg::*;

    localparam int DEG_UNITS    = STEPS_PER_DEGREE * FRAC_ONE;
    localparam int UNITS_FULL   = 4 * UNITS_QUARTER;
    localparam int RANDOM_ITEMS = 830;
    localparam int IDLE_LIMIT   = 1000;
    localparam int DRAIN_CYCLES = 20;
    localparam int N_DIRECTED   = 23;

    // One directed angle; want is only used when known is set
    typedef struct packed {
        t_action                   act;
        logic [ANGLE_W-1:0]        ang;
        logic                      known;
        logic signed [VALUE_W-1:0] want;
    } t_angle_row;

    t_angle_row directed_rows [N_DIRECTED] = '{
        '{ACT_COSINE, ANGLE_W'(0),                 1'b1, 16'sd32767},
        '{ACT_SINE,   ANGLE_W'(0),                 1'b1, 16'sd0},
        '{ACT_COSINE, ANGLE_W'(UNITS_QUARTER),     1'b1, 16'sd0},
        '{ACT_SINE,   ANGLE_W'(UNITS_QUARTER),     1'b1, 16'sd32767},
        '{ACT_COSINE, ANGLE_W'(2 * UNITS_QUARTER), 1'b1, -16'sd32767},
        '{ACT_SINE,   ANGLE_W'(2 * UNITS_QUARTER), 1'b1, 16'sd0},
        '{ACT_COSINE, ANGLE_W'(3 * UNITS_QUARTER), 1'b1, 16'sd0},
        '{ACT_SINE,   ANGLE_W'(3 * UNITS_QUARTER), 1'b1, -16'sd32767},
        '{ACT_COSINE, ANGLE_W'(UNITS_FULL),        1'b1, 16'sd32767},
        '{ACT_SINE,   ANGLE_W'(UNITS_FULL),        1'b1, 16'sd0},
        '{ACT_COSINE, ANGLE_W'(UNITS_FULL - 1),    1'b0, 16'sd0},
        '{ACT_SINE,   ANGLE_W'(UNITS_FULL - 1),    1'b0, 16'sd0},
        '{ACT_COSINE, {ANGLE_W{1'b1}},             1'b0, 16'sd0},
        '{ACT_SINE,   {ANGLE_W{1'b1}},             1'b0, 16'sd0},
        '{ACT_COSINE, ANGLE_W'(UNITS_QUARTER - 1), 1'b0, 16'sd0},
        '{ACT_SINE,   ANGLE_W'(UNITS_QUARTER + 1), 1'b0, 16'sd0},
        '{ACT_COSINE, ANGLE_W'(2 * UNITS_QUARTER - 1), 1'b0, 16'sd0},
        '{ACT_SINE,   ANGLE_W'(3 * UNITS_QUARTER - 1), 1'b0, 16'sd0},
        '{ACT_COSINE, ANGLE_W'(1),                 1'b0, 16'sd0},
        '{ACT_SINE,   ANGLE_W'(FRAC_HALF),         1'b0, 16'sd0},
        '{ACT_COSINE, ANGLE_W'(FRAC_ONE - 1),      1'b0, 16'sd0},
        '{ACT_SINE,   ANGLE_W'(60 * DEG_UNITS),    1'b0, 16'sd0},
        '{ACT_COSINE, ANGLE_W'(45 * DEG_UNITS + FRAC_HALF), 1'b0, 16'sd0}
    };

    logic                      i_clk   = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_valid = 1'b0;
    logic                      o_ready;
    logic                      i_action = 1'b0;
    logic [ANGLE_W-1:0]        i_angle  = '0;
    logic                      o_valid;
    logic                      i_ready  = 1'b0;
    logic signed [VALUE_W-1:0] o_value;

    logic [SAMPLE_W-1:0]       qw_samples [ROM_DEPTH];
    logic signed [VALUE_W-1:0] pending_values [$];
    bit                        no_idle = 1'b0;
    int                        mismatches  = 0;
    int                        angles_sent = 0;
    int                        values_seen = 0;
    int                        idle_cycles = 0;

    quadrant_folded_sine_cosine_lut_top i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_action(i_action),
        .i_angle (i_angle),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_value (o_value)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Fold into the first quadrant, interpolate two table samples, apply the sign
    function automatic logic signed [VALUE_W-1:0] sincos_of(t_action act,
                                                            logic [ANGLE_W-1:0] ang);
        logic [63:0] a, quad, r, t, idx, frac, lo, hi, v;
        bit          mirror, neg;
        a    = 64'(ang) % 64'(UNITS_FULL);
        quad = a / 64'(UNITS_QUARTER);
        r    = a - quad * 64'(UNITS_QUARTER);
        if (act == ACT_SINE) begin
            mirror = (quad == QUAD_0) || (quad == QUAD_2);
            neg    = (quad >= QUAD_2);
        end else begin
            mirror = (quad == QUAD_1) || (quad == QUAD_3);
            neg    = (quad == QUAD_1) || (quad == QUAD_2);
        end
        t    = mirror ? (64'(UNITS_QUARTER) - r) : r;
        idx  = t >> FRAC_BITS;
        frac = t & 64'(FRAC_ONE - 1);
        if (idx > 64'(STEPS_QUARTER)) begin
            idx = 64'(STEPS_QUARTER);
        end
        lo = 64'(qw_samples[idx]);
        hi = 64'(qw_samples[idx + 1]);
        v  = (lo * (64'(FRAC_ONE) - frac) + hi * frac + 64'(FRAC_HALF)) >> FRAC_BITS;
        if (v > 64'd32767) begin
            v = 64'd32767;
        end
        return VALUE_W'(neg ? (64'd0 - v) : v);
    endfunction

    task automatic report_mismatch(string what, logic signed [VALUE_W-1:0] got,
                                   logic signed [VALUE_W-1:0] want);
        mismatches++;
        $display("MISMATCH %0d at %0t: %s, got %0d expected %0d",
                 mismatches, $realtime, what, got, want);
    endtask

    // Present one angle after a random gap and hold it until accepted
    task automatic drive_angle(t_action act, logic [ANGLE_W-1:0] ang, logic known,
                               logic signed [VALUE_W-1:0] want);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid  <= 1'b1;
        i_action <= act;
        i_angle  <= ang;
        do @(posedge i_clk); while (!o_ready);
        pending_values.push_back(known ? want : sincos_of(act, ang));
        angles_sent++;
    endtask

    task automatic wait_results_drained();
        while (pending_values.size() != 0) @(posedge i_clk);
    endtask

    // Result side: random stall, then take one item and check it
    initial begin
        logic signed [VALUE_W-1:0] want;
        int                        stall;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 9);
            if (stall > 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!o_valid);
            values_seen++;
            if (pending_values.size() == 0) begin
                report_mismatch("result with no angle pending", o_value, 16'sd0);
            end else begin
                want = pending_values.pop_front();
                if (o_value !== want) begin
                    report_mismatch("value", o_value, want);
                end
            end
        end
    end

    // Watchdog on cycles without any accepted item
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        logic [63:0]        x, xsq, term;
        logic signed [63:0] acc, q;
        logic [ANGLE_W-1:0] ang;
        int                 k, pick, base, off;

        // Quarter-wave cosine table, Taylor series in Q2.30 rounded to Q1.15
        for (int i = 0; i < STEPS_QUARTER; i++) begin
            x    = (64'(i) * PI_Q30 + 64'(180 * STEPS_PER_DEGREE) / 2)
                   / 64'(180 * STEPS_PER_DEGREE);
            xsq  = (x * x) >> 30;
            term = ONE_Q30;
            acc  = $signed(ONE_Q30);
            k    = 1;
            while (k <= 12 && term != 64'd0) begin
                term = ((term * xsq) >> 30) / 64'((2 * k - 1) * (2 * k));
                if (k % 2 == 1) begin
                    acc = acc - $signed(term);
                end else begin
                    acc = acc + $signed(term);
                end
                k++;
            end
            if (acc < 0) begin
                acc = 0;
            end
            q = (acc + 64'sd16384) / 64'sd32768;
            if (q > 64'sd32767) begin
                q = 64'sd32767;
            end
            qw_samples[i] = SAMPLE_W'(q);
        end
        qw_samples[STEPS_QUARTER]     = '0;
        qw_samples[STEPS_QUARTER + 1] = '0;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: quadrant boundaries, wrap past 360, fraction extremes
        for (int n = 0; n < N_DIRECTED; n++) begin
            drive_angle(directed_rows[n].act, directed_rows[n].ang,
                        directed_rows[n].known, directed_rows[n].want);
        end
        i_valid <= 1'b0;
        wait_results_drained();

        // Random angles, weighted toward boundaries and fraction corners
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 50 == 0) begin
                no_idle = ($urandom_range(0, 3) == 0);
            end
            if (n == RANDOM_ITEMS / 2) begin
                i_valid <= 1'b0;
                wait_results_drained();
            end
            pick = $urandom_range(0, 9);
            if (pick <= 3) begin
                ang = ANGLE_W'($urandom_range(0, UNITS_FULL - 1));
            end else if (pick == 4) begin
                ang = ANGLE_W'($urandom());
            end else if (pick <= 7) begin
                base = $urandom_range(0, 4) * UNITS_QUARTER;
                off  = $urandom_range(0, 600) - 300;
                ang  = (base + off < 0) ? '0 : ANGLE_W'(base + off);
            end else begin
                base = $urandom_range(0, 4 * STEPS_QUARTER - 1) * FRAC_ONE;
                case ($urandom_range(0, 5))
                    0: off = 0;
                    1: off = 1;
                    2: off = FRAC_HALF - 1;
                    3: off = FRAC_HALF;
                    4: off = FRAC_HALF + 1;
                    default: off = FRAC_ONE - 1;
                endcase
                ang = ANGLE_W'(base + off);
            end
            drive_angle(t_action'($urandom_range(0, 1)), ang, 1'b0, 16'sd0);
        end
        i_valid <= 1'b0;
        no_idle = 1'b0;

        wait_results_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("angles sent: %0d (%0d directed, rest random incl. wrap past 360 deg)",
                 angles_sent, N_DIRECTED);
        $display("values checked: %0d, mismatches: %0d", values_seen, mismatches);
        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

// File: quadrant_folded_sine_cosine_lut_top.f
rtl/qfsc_pkg.sv
rtl/qfsc_front.sv
rtl/qfsc_queue.sv
rtl/qfsc_back.sv
rtl/quadrant_folded_sine_cosine_lut_top.sv
rtl/qfsc_checker.sv
tb/tb_quadrant_folded_sine_cosine_lut_top.sv
